@@ hw/rtl/record_sort_by_id_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the record sorter
// Shared helpers that wrap concurrent assertions on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef RECORD_SORT_BY_ID_DEFINES_SVH
`define RECORD_SORT_BY_ID_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rsbi_pkg.sv @@
// ----------------------------------------------------------------------------
// Record sorter package
// Widths, defaults, cell operation codes and the cell control word.
// ----------------------------------------------------------------------------
package rsbi_pkg;

	localparam int MAX_RECORDS_DEF = 64;
	localparam int ID_BITS_DEF     = 16;
	localparam int ID_PORT_BITS    = 16;
	localparam int TAG_BITS        = 6;

	localparam logic [2:0] OP_HOLD  = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_EVEN  = 3'd2;
	localparam logic [2:0] OP_ODD   = 3'd3;
	localparam logic [2:0] OP_SHIFT = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic       desc;
	} ctrl_t;

endpackage

@@ hw/rtl/rsbi_cell.sv @@
// ----------------------------------------------------------------------------
// Record sorter cell
// Holds one record; loads it, compare-exchanges it with a neighbor, or shifts.
// ----------------------------------------------------------------------------
module rsbi_cell #(
	parameter int ID_BITS = rsbi_pkg::ID_BITS_DEF,
	parameter bit IDX_ODD = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsbi_pkg::ctrl_t               ctrl,
	input  logic                          load_sel,
	input  logic [ID_BITS-1:0]            load_id,
	input  logic [rsbi_pkg::TAG_BITS-1:0] load_tag,
	input  logic                          left_vld,
	input  logic [ID_BITS-1:0]            left_id,
	input  logic [rsbi_pkg::TAG_BITS-1:0] left_tag,
	input  logic                          right_vld,
	input  logic [ID_BITS-1:0]            right_id,
	input  logic [rsbi_pkg::TAG_BITS-1:0] right_tag,
	output logic                          vld,
	output logic [ID_BITS-1:0]            id,
	output logic [rsbi_pkg::TAG_BITS-1:0] tag
);

	logic                          vld_q;
	logic [ID_BITS-1:0]            id_q;
	logic [rsbi_pkg::TAG_BITS-1:0] tag_q;
	logic                          left_role;
	logic [ID_BITS-1:0]            a_id;
	logic [ID_BITS-1:0]            b_id;
	logic                          pair_vld;
	logic                          swap;
	logic                          vld_d;
	logic [ID_BITS-1:0]            id_d;
	logic [rsbi_pkg::TAG_BITS-1:0] tag_d;

	always_comb begin
		left_role = (ctrl.op == rsbi_pkg::OP_EVEN) ? !IDX_ODD : IDX_ODD;
		a_id      = left_role ? id_q : left_id;
		b_id      = left_role ? right_id : id_q;
		pair_vld  = left_role ? (vld_q && right_vld) : (left_vld && vld_q);
		swap      = pair_vld && (ctrl.desc ? (a_id < b_id) : (a_id > b_id));
	end

	always_comb begin
		vld_d = vld_q;
		id_d  = id_q;
		tag_d = tag_q;
		case (ctrl.op)
			rsbi_pkg::OP_LOAD: begin
				if (load_sel) begin
					vld_d = 1'b1;
					id_d  = load_id;
					tag_d = load_tag;
				end
			end
			rsbi_pkg::OP_EVEN, rsbi_pkg::OP_ODD: begin
				if (swap) begin
					id_d  = left_role ? right_id : left_id;
					tag_d = left_role ? right_tag : left_tag;
				end
			end
			rsbi_pkg::OP_SHIFT: begin
				vld_d = right_vld;
				id_d  = right_id;
				tag_d = right_tag;
			end
			default: begin
				vld_d = vld_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q  <= id_d;
		tag_q <= tag_d;
	end

	assign vld = vld_q;
	assign id  = id_q;
	assign tag = tag_q;

endmodule

@@ hw/rtl/record_sort_by_id.sv @@
// ----------------------------------------------------------------------------
// Record sorter by ID
// Collects a set of records, sorts it stably by ID and emits it in order.
// ----------------------------------------------------------------------------
// Records arrive as words on the in channel (item_id, item_tag, set_last) and
// are written into a row of cells in arrival order, one word per cycle.
// The word with set_last closes the set. A store that is full drops further
// words and flags overflow on every word of the emitted set.
// After the set closes, the cells run n rounds of odd-even compare-exchange
// with their neighbors, n being the number of held records, and then shift
// the sorted set out of cell 0 on the out channel, one word per cycle while
// out_ready is high, with out_last on the final word. The in channel is not
// ready while a set is sorted or emitted; a stalled receiver simply holds the
// head word and the row of cells.
// The cfg channel is always ready; its single bit selects descending order.
// Reset empties the row, clears the count and flag and selects ascending order.
// ----------------------------------------------------------------------------
`include "record_sort_by_id_defines.svh"

module record_sort_by_id #(
	parameter int MAX_RECORDS = rsbi_pkg::MAX_RECORDS_DEF,
	parameter int ID_BITS     = rsbi_pkg::ID_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rsbi_pkg::ID_PORT_BITS-1:0]     item_id,
	input  logic [rsbi_pkg::TAG_BITS-1:0]         item_tag,
	input  logic                                  set_last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rsbi_pkg::ID_PORT_BITS-1:0]     sorted_id,
	output logic [rsbi_pkg::TAG_BITS-1:0]         sorted_tag,
	output logic                                  out_last,
	output logic                                  overflow
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int WIDE_W = (ID_BITS > rsbi_pkg::ID_PORT_BITS) ? ID_BITS
		: rsbi_pkg::ID_PORT_BITS;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] phase_q;
	logic             drop_q;
	logic             desc_q;

	logic                          in_acc;
	logic                          out_acc;
	logic                          full;
	logic [WIDE_W-1:0]             in_wide;
	logic [ID_BITS-1:0]            load_id;
	logic [WIDE_W-1:0]             out_wide;
	rsbi_pkg::ctrl_t               ctrl;

	logic                          cell_vld [MAX_RECORDS];
	logic [ID_BITS-1:0]            cell_id  [MAX_RECORDS];
	logic [rsbi_pkg::TAG_BITS-1:0] cell_tag [MAX_RECORDS];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign full      = (count_q == CNT_W'(MAX_RECORDS));

	assign in_wide = WIDE_W'(item_id);
	assign load_id = in_wide[ID_BITS-1:0];

	always_comb begin
		ctrl.desc = desc_q;
		ctrl.op   = rsbi_pkg::OP_HOLD;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && !full) begin
					ctrl.op = rsbi_pkg::OP_LOAD;
				end
			end
			ST_SORT: begin
				ctrl.op = phase_q[0] ? rsbi_pkg::OP_ODD : rsbi_pkg::OP_EVEN;
			end
			ST_EMIT: begin
				if (out_acc) begin
					ctrl.op = rsbi_pkg::OP_SHIFT;
				end
			end
			default: begin
				ctrl.op = rsbi_pkg::OP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			desc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			phase_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (set_last) begin
							state_q <= ST_SORT;
							phase_q <= '0;
						end
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + CNT_W'(1);
					if (phase_q == count_q - CNT_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_LOAD;
							drop_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		logic                          l_vld;
		logic [ID_BITS-1:0]            l_id;
		logic [rsbi_pkg::TAG_BITS-1:0] l_tag;
		logic                          r_vld;
		logic [ID_BITS-1:0]            r_id;
		logic [rsbi_pkg::TAG_BITS-1:0] r_tag;

		if (i == 0) begin : g_left_edge
			assign l_vld = 1'b0;
			assign l_id  = '0;
			assign l_tag = '0;
		end else begin : g_left
			assign l_vld = cell_vld[i-1];
			assign l_id  = cell_id[i-1];
			assign l_tag = cell_tag[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_right_edge
			assign r_vld = 1'b0;
			assign r_id  = '0;
			assign r_tag = '0;
		end else begin : g_right
			assign r_vld = cell_vld[i+1];
			assign r_id  = cell_id[i+1];
			assign r_tag = cell_tag[i+1];
		end

		rsbi_cell #(
			.ID_BITS (ID_BITS),
			.IDX_ODD (1'((i % 2)))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.load_sel  (count_q == CNT_W'(i)),
			.load_id   (load_id),
			.load_tag  (item_tag),
			.left_vld  (l_vld),
			.left_id   (l_id),
			.left_tag  (l_tag),
			.right_vld (r_vld),
			.right_id  (r_id),
			.right_tag (r_tag),
			.vld       (cell_vld[i]),
			.id        (cell_id[i]),
			.tag       (cell_tag[i])
		);
	end

	assign out_wide   = WIDE_W'(cell_id[0]);
	assign sorted_id  = out_wide[rsbi_pkg::ID_PORT_BITS-1:0];
	assign sorted_tag = cell_tag[0];
	assign out_last   = (count_q == CNT_W'(1));
	assign overflow   = drop_q;

	`RSBI_ASSERT_NOW(a_emit_has_word, clk, arst_n, out_valid,
		(count_q != '0) && cell_vld[0], "emitting with an empty row")
	`RSBI_ASSERT_NEXT(a_full_drops, clk, arst_n, in_acc && full,
		drop_q, "word arriving at a full store was not flagged")
	`RSBI_ASSERT_NEXT(a_last_ends_set, clk, arst_n, out_acc && out_last,
		in_ready && (count_q == '0) && !drop_q, "set did not close after last word")
	`RSBI_ASSERT_NOW(a_sort_nonempty, clk, arst_n, state_q == ST_SORT,
		(count_q != '0) && !in_ready && !out_valid, "sorting an empty set")

endmodule
